@@ src/wavcv_pkg.sv @@
// ----------------------------------------------------------------------------
// wavcv_pkg
// shared types and constants of the pcm24 to pcm16 wave converter
// ----------------------------------------------------------------------------
package wavcv_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] out_byte;
      logic [2:0] status;
      logic       run_end;
   } rsp_type;

   // command from parser to emitter
   typedef enum logic [1:0] {
      CMD_HEADER = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_STATUS = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         last;      // last command of this input item
      logic         fin;       // final byte: a status item closes the command
      logic [15:0]  sample;
      logic [2:0]   status;
      logic [31:0]  conv;
      logic [15:0]  channels;
      logic [31:0]  rate;
   } cmd_type;

   localparam int CMD_W = $bits(cmd_type);

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_SHORT = 3'd1;
   localparam logic [2:0] ST_TAGS  = 3'd2;
   localparam logic [2:0] ST_FMT   = 3'd3;
   localparam logic [2:0] ST_UNSUP = 3'd4;
   localparam logic [2:0] ST_SIZE  = 3'd5;
   localparam logic [2:0] ST_TRUNC = 3'd6;

   localparam logic [31:0] TAG_RIFF = 32'h52494646;
   localparam logic [31:0] TAG_WAVE = 32'h57415645;
   localparam logic [31:0] TAG_FMT  = 32'h666D7420;
   localparam logic [31:0] TAG_DATA = 32'h64617461;

   localparam int HDR_BYTES = 44;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef enum logic [6:0] {
      PH_FILE = 7'b0000001,
      PH_CHDR = 7'b0000010,
      PH_BODY = 7'b0000100,
      PH_PAD  = 7'b0001000,
      PH_DATA = 7'b0010000,
      PH_TAIL = 7'b0100000,
      PH_ERR  = 7'b1000000
   } phase_type;

endpackage

@@ src/wav_pcm24_to_pcm16_converter_unit.sv @@
// ----------------------------------------------------------------------------
// wav_pcm24_to_pcm16_converter_unit
// riff/wave pcm24 stream to pcm16 stream converter, queue-style ports
// ----------------------------------------------------------------------------
// usage
//   input: one file byte per item on req_item, pushed with req_push while
//   req_full is low; is_final marks the last byte of the file
//   output: rsp_item is valid while rsp_empty is low, taken with rsp_pop
//   each item makes zero or more results: a 44-byte pcm16 header when a good
//   data chunk header completes, two bytes per 3-byte sample, and a status
//   item on the final byte; run_end flags the last result of an item
// throughput and flow
//   the parser takes one item per cycle while the command queue has room;
//   commands reach the output through the queue and the skid buffer, both
//   registered, the header later as the byte-rate multiply is registered
//   the emitter drains one result per cycle unless the skid buffer is full;
//   a header burst waits for the byte rate, then 44 bytes; the command queue
//   holds the sample commands arriving meanwhile and req_full rises once full
// reset and stalls
//   reset clears parser state and empties both queues; after a final byte
//   the parser returns to its reset state by itself
//   when the receiver stops popping, the skid buffer and command queue fill
//   and req_full rises; no item is lost
// ----------------------------------------------------------------------------
module wav_pcm24_to_pcm16_converter_unit #(
   parameter int QUEUE_DEPTH = wavcv_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  wavcv_pkg::req_type req_item,
   output logic               req_full,
   output logic               rsp_empty,
   output wavcv_pkg::rsp_type rsp_item,
   input  logic               rsp_pop
);
   import wavcv_pkg::*;

   // parser to queue
   logic    p_valid, p_ready, in_ready;
   cmd_type p_cmd;
   // queue to emitter
   logic    q_valid, q_ready;
   cmd_type q_cmd;
   // emitter to skid buffer
   logic    e_valid, e_ready, o_valid;
   rsp_type e_item;

   assign req_full = ~in_ready;

   wavcv_parser u_parser (
      .clock(clock), .reset(reset),
      .in_valid(req_push), .in_item(req_item), .in_ready(in_ready),
      .cmd_valid(p_valid), .cmd_item(p_cmd), .cmd_ready(p_ready)
   );

   wavcv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(p_valid), .wr_item(p_cmd), .wr_ready(p_ready),
      .rd_valid(q_valid), .rd_item(q_cmd), .rd_ready(q_ready)
   );

   wavcv_emitter u_emitter (
      .clock(clock), .reset(reset),
      .cmd_valid(q_valid), .cmd_item(q_cmd), .cmd_ready(q_ready),
      .out_valid(e_valid), .out_item(e_item), .out_ready(e_ready)
   );

   wavcv_outbuf u_outbuf (
      .clock(clock), .reset(reset),
      .in_valid(e_valid), .in_item(e_item), .in_ready(e_ready),
      .out_valid(o_valid), .out_item(rsp_item), .out_ready(rsp_pop)
   );

   assign rsp_empty = ~o_valid;

   // a status item always closes its run
   a_status_ends_run: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.kind) |-> rsp_item.run_end)
      else $error("status item without run_end");

   // byte items carry no status
   a_byte_no_status: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_item.kind) |-> (rsp_item.status == ST_OK))
      else $error("byte item with status");

   // full only when the command queue cannot take more
   a_full_means_queue_full: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !p_ready)
      else $error("input stalled with room in queue");
endmodule

@@ src/wavcv_parser.sv @@
// ----------------------------------------------------------------------------
// wavcv_parser
// byte-level riff walker posting emitter commands, one item per cycle unless stalled
// ----------------------------------------------------------------------------
module wavcv_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  wavcv_pkg::req_type in_item,
   output logic               in_ready,
   output logic               cmd_valid,
   output wavcv_pkg::cmd_type cmd_item,
   input  logic               cmd_ready
);
   import wavcv_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [5:0]  seen_ff, seen_in;
   logic [31:0] pos_ff, pos_in;
   logic [1:0]  sub_ff, sub_in;
   logic [31:0] id_ff, id_in;
   logic [31:0] len_ff, len_in;
   logic        fmt_seen_ff, fmt_seen_in;
   logic [31:0] fmt_len_ff, fmt_len_in;
   logic [15:0] afmt_ff, afmt_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] left_ff, left_in;
   logic [7:0]  hold_ff, hold_in;
   logic [2:0]  err_ff, err_in;
   // chunk_len times the inverse of 3 mod 2^32, built while length bytes arrive
   logic [31:0] q_ff, q_in;

   logic        take;
   logic        emit_hdr, emit_smp;
   logic [2:0]  fin_status;
   logic [31:0] new_id, new_len, new_q;
   logic        len_ok;

   assign in_ready = cmd_ready;
   assign take = in_valid & in_ready;

   always_comb begin
      logic [7:0]  b;
      logic [31:0] qp;
      b = in_item.in_byte;
      phase_in = phase_ff; seen_in = seen_ff; pos_in = pos_ff; sub_in = sub_ff;
      id_in = id_ff; len_in = len_ff; fmt_seen_in = fmt_seen_ff;
      fmt_len_in = fmt_len_ff; afmt_in = afmt_ff; chan_in = chan_ff;
      rate_in = rate_ff; bits_in = bits_ff; left_in = left_ff; hold_in = hold_ff;
      err_in = err_ff; q_in = q_ff;
      emit_hdr = 1'b0; emit_smp = 1'b0;
      new_id = {id_ff[23:0], b};
      new_len = len_ff;
      new_q = q_ff;
      qp = '0;
      len_ok = 1'b0;
      if (seen_ff != 6'(HDR_BYTES)) seen_in = seen_ff + 6'd1;
      case (phase_ff)
         PH_FILE: begin
            id_in = new_id;
            pos_in = pos_ff + 32'd1;
            if (pos_ff == 32'd3 && new_id != TAG_RIFF) begin
               err_in = ST_TAGS; phase_in = PH_ERR;
            end else if (pos_ff == 32'd7) begin
               id_in = 32'd0;
            end else if (pos_ff == 32'd11) begin
               if (new_id != TAG_WAVE) begin
                  err_in = ST_TAGS; phase_in = PH_ERR;
               end else begin
                  id_in = 32'd0; pos_in = 32'd0; phase_in = PH_CHDR;
               end
            end
         end
         PH_CHDR: begin
            if (pos_ff < 32'd4) begin
               id_in = new_id;
               if (pos_ff == 32'd0) begin
                  len_in = 32'd0; q_in = 32'd0;
               end
            end else begin
               case (pos_ff[1:0])
                  2'd0: new_len = {len_ff[31:8], b};
                  2'd1: new_len = {len_ff[31:16], b, len_ff[7:0]};
                  2'd2: new_len = {len_ff[31:24], b, len_ff[15:0]};
                  default: new_len = {b, len_ff[23:0]};
               endcase
               len_in = new_len;
               // exact quotient by 3 when the length is a multiple of 3
               qp = {24'd0, b} * 32'hAAAAAAAB;
               new_q = q_ff + (qp << {pos_ff[1:0], 3'b000});
               q_in = new_q;
            end
            pos_in = pos_ff + 32'd1;
            if (pos_ff == 32'd7) begin
               pos_in = 32'd0;
               if (id_ff == TAG_DATA) begin
                  // multiple of 3 exactly when the product lands in the low third
                  len_ok = (new_len >= 32'd3) && (new_q <= 32'h55555555);
                  if (!fmt_seen_ff || fmt_len_ff < 32'd16) err_in = ST_FMT;
                  else if (afmt_ff != 16'd1 || bits_ff != 16'd24 || chan_ff == 16'd0)
                     err_in = ST_UNSUP;
                  else if (!len_ok) err_in = ST_SIZE;
                  if (err_in != ST_OK) phase_in = PH_ERR;
                  else begin
                     emit_hdr = 1'b1; left_in = new_len; sub_in = 2'd0;
                     phase_in = PH_DATA;
                  end
               end else begin
                  if (id_ff == TAG_FMT) begin
                     fmt_seen_in = 1'b1; fmt_len_in = new_len;
                  end
                  if (new_len == 32'd0) begin
                     id_in = 32'd0; phase_in = PH_CHDR;
                  end else phase_in = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            if (id_ff == TAG_FMT) begin
               case (pos_ff)
                  32'd0:  afmt_in = {8'd0, b};
                  32'd1:  afmt_in = {b, afmt_ff[7:0]};
                  32'd2:  chan_in = {8'd0, b};
                  32'd3:  chan_in = {b, chan_ff[7:0]};
                  32'd4:  rate_in = {24'd0, b};
                  32'd5:  rate_in = {rate_ff[31:16], b, rate_ff[7:0]};
                  32'd6:  rate_in = {rate_ff[31:24], b, rate_ff[15:0]};
                  32'd7:  rate_in = {b, rate_ff[23:0]};
                  32'd14: bits_in = {8'd0, b};
                  32'd15: bits_in = {b, bits_ff[7:0]};
                  default: ;
               endcase
            end
            pos_in = pos_ff + 32'd1;
            if (pos_in == len_ff) begin
               pos_in = 32'd0; id_in = 32'd0;
               phase_in = len_ff[0] ? PH_PAD : PH_CHDR;
            end
         end
         PH_PAD: begin
            pos_in = 32'd0; id_in = 32'd0; phase_in = PH_CHDR;
         end
         PH_DATA: begin
            if (sub_ff == 2'd1) hold_in = b;
            else if (sub_ff == 2'd2) emit_smp = 1'b1;
            sub_in = (sub_ff == 2'd2) ? 2'd0 : sub_ff + 2'd1;
            left_in = left_ff - 32'd1;
            if (left_in == 32'd0) phase_in = PH_TAIL;
         end
         default: ;
      endcase
      if (seen_in != 6'(HDR_BYTES)) fin_status = ST_SHORT;
      else if (err_in != ST_OK) fin_status = err_in;
      else if (phase_in == PH_DATA) fin_status = ST_TRUNC;
      else if (phase_in == PH_TAIL) fin_status = ST_OK;
      else fin_status = ST_FMT;
   end

   // command: one per item at most; a final byte adds its status to it
   always_comb begin
      cmd_item = '0;
      cmd_item.kind = emit_hdr ? CMD_HEADER : (emit_smp ? CMD_SAMPLE : CMD_STATUS);
      cmd_item.sample = {in_item.in_byte, hold_ff};
      cmd_item.conv = {new_q[30:0], 1'b0};
      cmd_item.channels = chan_ff;
      cmd_item.rate = rate_ff;
      cmd_item.status = fin_status;
      cmd_item.last = 1'b1;
      cmd_item.fin = in_item.is_final;
      cmd_valid = take & (emit_hdr | emit_smp | in_item.is_final);
   end

   always_ff @(posedge clock) begin
      if (reset || (take && in_item.is_final)) begin
         phase_ff <= PH_FILE; seen_ff <= '0; pos_ff <= '0; sub_ff <= '0;
         id_ff <= '0; len_ff <= '0; fmt_seen_ff <= 1'b0; fmt_len_ff <= '0;
         afmt_ff <= '0; chan_ff <= '0; rate_ff <= '0; bits_ff <= '0;
         left_ff <= '0; hold_ff <= '0; err_ff <= '0; q_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in; seen_ff <= seen_in; pos_ff <= pos_in; sub_ff <= sub_in;
         id_ff <= id_in; len_ff <= len_in; fmt_seen_ff <= fmt_seen_in;
         fmt_len_ff <= fmt_len_in; afmt_ff <= afmt_in; chan_ff <= chan_in;
         rate_ff <= rate_in; bits_ff <= bits_in; left_ff <= left_in;
         hold_ff <= hold_in; err_ff <= err_in; q_ff <= q_in;
      end
   end
endmodule

@@ src/wavcv_queue.sv @@
// ----------------------------------------------------------------------------
// wavcv_queue
// small command fifo between parser and emitter
// ----------------------------------------------------------------------------
module wavcv_queue #(
   parameter int DEPTH = wavcv_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   input  wavcv_pkg::cmd_type wr_item,
   output logic               wr_ready,
   output logic               rd_valid,
   output wavcv_pkg::cmd_type rd_item,
   input  logic               rd_ready
);
   import wavcv_pkg::*;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cmd_type            mem_ff [DEPTH];
   logic [AW-1:0]      wp_ff, rp_ff;
   logic [AW:0]        cnt_ff;
   logic               wr, rd;

   assign wr_ready = (cnt_ff != (AW+1)'(DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_item = mem_ff[rp_ff];
   assign wr = wr_valid & wr_ready;
   assign rd = rd_valid & rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + AW'(1);
         if (rd) rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + AW'(1);
         cnt_ff <= cnt_ff + (AW+1)'(wr) - (AW+1)'(rd);
      end
   end

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_item;
   end
endmodule

@@ src/wavcv_emitter.sv @@
// ----------------------------------------------------------------------------
// wavcv_emitter
// expands commands into result items: 44-byte header, sample pairs, status
// ----------------------------------------------------------------------------
module wavcv_emitter (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  wavcv_pkg::cmd_type cmd_item,
   output logic               cmd_ready,
   output logic               out_valid,
   output wavcv_pkg::rsp_type out_item,
   input  logic               out_ready
);
   import wavcv_pkg::*;

   logic [5:0]  idx_ff, idx_in;
   logic [31:0] brate_ff;
   logic        brate_ok_ff;
   logic [15:0] align;
   logic [5:0]  base;
   logic [5:0]  count;
   logic        step;

   // byte rate: registered before the header reaches its field
   logic [47:0] prod;
   assign prod = {16'd0, cmd_item.rate} * {32'd0, cmd_item.channels};
   assign align = {cmd_item.channels[14:0], 1'b0};

   always_comb begin
      case (cmd_item.kind)
         CMD_HEADER: base = 6'(HDR_BYTES);
         CMD_SAMPLE: base = 6'd2;
         default:    base = 6'd0;
      endcase
      // a final byte appends its status item
      count = base + {5'd0, cmd_item.fin};
   end

   always_ff @(posedge clock) begin
      brate_ff <= {prod[30:0], 1'b0};
   end

   // set only while the same header command stays at the head
   always_ff @(posedge clock) begin
      if (reset) brate_ok_ff <= 1'b0;
      else brate_ok_ff <= cmd_valid & (cmd_item.kind == CMD_HEADER) & !cmd_ready;
   end

   always_comb begin
      logic [7:0] v;
      v = 8'd0;
      case (idx_ff)
         6'd0: v = 8'h52; 6'd1: v = 8'h49; 6'd2: v = 8'h46; 6'd3: v = 8'h46;
         6'd4: v = 8'(cmd_item.conv + 32'd36);
         6'd5: v = 8'((cmd_item.conv + 32'd36) >> 8);
         6'd6: v = 8'((cmd_item.conv + 32'd36) >> 16);
         6'd7: v = 8'((cmd_item.conv + 32'd36) >> 24);
         6'd8: v = 8'h57; 6'd9: v = 8'h41; 6'd10: v = 8'h56; 6'd11: v = 8'h45;
         6'd12: v = 8'h66; 6'd13: v = 8'h6D; 6'd14: v = 8'h74; 6'd15: v = 8'h20;
         6'd16: v = 8'd16;
         6'd20: v = 8'd1;
         6'd22: v = cmd_item.channels[7:0];
         6'd23: v = cmd_item.channels[15:8];
         6'd24: v = cmd_item.rate[7:0];
         6'd25: v = cmd_item.rate[15:8];
         6'd26: v = cmd_item.rate[23:16];
         6'd27: v = cmd_item.rate[31:24];
         6'd28: v = brate_ff[7:0];
         6'd29: v = brate_ff[15:8];
         6'd30: v = brate_ff[23:16];
         6'd31: v = brate_ff[31:24];
         6'd32: v = align[7:0];
         6'd33: v = align[15:8];
         6'd34: v = 8'd16;
         6'd36: v = 8'h64; 6'd37: v = 8'h61; 6'd38: v = 8'h74; 6'd39: v = 8'h61;
         6'd40: v = cmd_item.conv[7:0];
         6'd41: v = cmd_item.conv[15:8];
         6'd42: v = cmd_item.conv[23:16];
         6'd43: v = cmd_item.conv[31:24];
         default: v = 8'd0;
      endcase
      out_item = '0;
      if (cmd_item.fin && idx_ff == count - 6'd1) begin
         out_item.kind = 1'b1;
         out_item.status = cmd_item.status;
      end else begin
         case (cmd_item.kind)
            CMD_HEADER: out_item.out_byte = v;
            CMD_SAMPLE: out_item.out_byte = idx_ff[0] ? cmd_item.sample[15:8]
                                                      : cmd_item.sample[7:0];
            default: ;
         endcase
      end
      out_item.run_end = (idx_ff == count - 6'd1) & cmd_item.last;
   end

   // header waits at entry for the byte-rate register
   assign out_valid = cmd_valid &
                      !((cmd_item.kind == CMD_HEADER) && idx_ff == 6'd0 && !brate_ok_ff);
   assign step = out_valid & out_ready;
   assign cmd_ready = step & (idx_ff == count - 6'd1);
   assign idx_in = cmd_ready ? 6'd0 : idx_ff + 6'd1;

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else if (step) idx_ff <= idx_in;
   end
endmodule

@@ src/wavcv_outbuf.sv @@
// ----------------------------------------------------------------------------
// wavcv_outbuf
// two-entry skid buffer on the result side
// ----------------------------------------------------------------------------
module wavcv_outbuf (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  wavcv_pkg::rsp_type in_item,
   output logic               in_ready,
   output logic               out_valid,
   output wavcv_pkg::rsp_type out_item,
   input  logic               out_ready
);
   import wavcv_pkg::*;

   rsp_type    buf_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       wr, rd;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item = buf_ff[rp_ff];
   assign wr = in_valid & in_ready;
   assign rd = out_valid & out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(wr) - 2'(rd);
      end
   end

   always_ff @(posedge clock) begin
      if (wr) buf_ff[wp_ff] <= in_item;
   end
endmodule

@@ tb/wav_pcm24_to_pcm16_converter_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_pcm24_to_pcm16_converter_unit_tb
// self-checking bench for the riff/wave pcm24 to pcm16 stream converter
// builds wave files byte by byte (good ones, broken tags, bad formats, bad
// sizes, truncated and short files), pushes them through the input queue
// port, mirrors the parser in a bit-exact predictor and compares every
// result item, field by field, in arrival order
// ----------------------------------------------------------------------------
module wav_pcm24_to_pcm16_converter_unit_tb;
   import wavcv_pkg::*;

   // kinds of file the generator can build
   typedef enum int {
      F_GOOD, F_BAD_RIFF, F_BAD_WAVE, F_NO_FMT, F_SMALL_FMT, F_BAD_FMT,
      F_BAD_BITS, F_NO_CHAN, F_BAD_SIZE, F_TINY_SIZE, F_NO_DATA, F_FMT_LATE
   } flaw_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_item = '0;
   logic    req_full;
   logic    rsp_empty;
   rsp_type rsp_item;
   logic    rsp_pop = 1'b0;

   wav_pcm24_to_pcm16_converter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item),
      .rsp_pop   (rsp_pop)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // file bytes waiting to be pushed, and results still to arrive
   req_type  pending_bytes[$];
   rsp_type  expected_out[$];
   rsp_type  step_out[$];
   logic [7:0] file_buf[$];

   int  fail_count = 0;
   int  bytes_sent = 0;
   int  results_seen = 0;
   int  total_bytes = 0;
   int  drain_pause_at = 20;
   logic quiet = 1'b0;

   // mirrored parser state
   phase_type   cv_phase;
   logic [5:0]  cv_seen;
   logic [31:0] cv_pos, cv_id, cv_len, cv_fmt_len, cv_rate, cv_left;
   logic        cv_fmt_seen;
   logic [15:0] cv_format, cv_chans, cv_bits, cv_hold;
   logic [2:0]  cv_err;

   task automatic clear_parser();
      cv_phase = PH_FILE;
      cv_seen = '0;
      cv_pos = '0; cv_id = '0; cv_len = '0; cv_fmt_len = '0;
      cv_rate = '0; cv_left = '0; cv_fmt_seen = 1'b0;
      cv_format = '0; cv_chans = '0; cv_bits = '0; cv_hold = '0;
      cv_err = ST_OK;
   endtask

   task automatic emit_byte(input logic [7:0] b);
      rsp_type r;
      r = '{kind: 1'b0, out_byte: b, status: ST_OK, run_end: 1'b0};
      step_out = {step_out, r};
   endtask

   // little-endian field of n bytes
   task automatic emit_le(input logic [31:0] v, input int n);
      for (int i = 0; i < n; i++) emit_byte(v[8*i +: 8]);
   endtask

   task automatic emit_tag(input logic [31:0] t);
      for (int i = 3; i >= 0; i--) emit_byte(t[8*i +: 8]);
   endtask

   // one input byte through the mirrored parser; results go to expected_out
   task automatic absorb_byte(input logic [7:0] b, input logic fin);
      logic [31:0] conv;
      logic [2:0]  st;
      rsp_type     r;
      step_out.delete();
      if (cv_seen < 6'd44) cv_seen++;
      case (cv_phase)
         PH_FILE: begin
            cv_id = {cv_id[23:0], b};
            if (cv_pos == 3 && cv_id != TAG_RIFF) begin
               cv_err = ST_TAGS;
               cv_phase = PH_ERR;
            end else begin
               if (cv_pos == 7) cv_id = '0;
               if (cv_pos == 11) begin
                  if (cv_id != TAG_WAVE) begin
                     cv_err = ST_TAGS;
                     cv_phase = PH_ERR;
                  end else begin
                     cv_id = '0;
                     cv_pos = '0;
                     cv_phase = PH_CHDR;
                  end
               end else cv_pos++;
            end
         end
         PH_CHDR: begin
            if (cv_pos < 4) begin
               cv_id = {cv_id[23:0], b};
               if (cv_pos == 0) cv_len = '0;
            end else cv_len |= {24'd0, b} << (8 * ((cv_pos - 4) & 3));
            if (cv_pos != 7) cv_pos++;
            else begin
               // chunk header complete
               cv_pos = '0;
               if (cv_id == TAG_DATA) begin
                  if (!cv_fmt_seen || cv_fmt_len < 16) cv_err = ST_FMT;
                  else if (cv_format != 1 || cv_bits != 24 || cv_chans == 0)
                     cv_err = ST_UNSUP;
                  else if (cv_len < 3 || (cv_len % 3) != 0) cv_err = ST_SIZE;
                  if (cv_err != ST_OK) cv_phase = PH_ERR;
                  else begin
                     conv = (cv_len / 3) * 2;
                     emit_tag(TAG_RIFF);
                     emit_le(32'd36 + conv, 4);
                     emit_tag(TAG_WAVE);
                     emit_tag(TAG_FMT);
                     emit_le(32'd16, 4);
                     emit_le(32'd1, 2);
                     emit_le({16'd0, cv_chans}, 2);
                     emit_le(cv_rate, 4);
                     emit_le(cv_rate * {16'd0, cv_chans} * 32'd2, 4);
                     emit_le({16'd0, cv_chans} * 32'd2, 2);
                     emit_le(32'd16, 2);
                     emit_tag(TAG_DATA);
                     emit_le(conv, 4);
                     cv_left = cv_len;
                     cv_phase = PH_DATA;
                  end
               end else begin
                  if (cv_id == TAG_FMT) begin
                     cv_fmt_seen = 1'b1;
                     cv_fmt_len = cv_len;
                  end
                  if (cv_len == 0) begin
                     cv_id = '0;
                     cv_phase = PH_CHDR;
                  end else cv_phase = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            if (cv_id == TAG_FMT) begin
               case (cv_pos)
                  0:  cv_format[7:0] = b;
                  1:  cv_format[15:8] = b;
                  2:  cv_chans = {8'd0, b};
                  3:  cv_chans[15:8] = b;
                  4:  cv_rate = {24'd0, b};
                  5:  cv_rate[15:8] = b;
                  6:  cv_rate[23:16] = b;
                  7:  cv_rate[31:24] = b;
                  14: cv_bits = {8'd0, b};
                  15: cv_bits[15:8] = b;
                  default: ;
               endcase
               // writing the low byte of format also clears its upper byte
               if (cv_pos == 0) cv_format[15:8] = 8'd0;
            end
            cv_pos++;
            if (cv_pos == cv_len) begin
               cv_pos = '0;
               cv_id = '0;
               cv_phase = cv_len[0] ? PH_PAD : PH_CHDR;
            end
         end
         PH_PAD: begin
            cv_pos = '0;
            cv_id = '0;
            cv_phase = PH_CHDR;
         end
         PH_DATA: begin
            // middle byte held, top byte completes the 16-bit sample
            if (cv_pos % 3 == 1) cv_hold = {8'd0, b};
            else if (cv_pos % 3 == 2) begin
               emit_byte(cv_hold[7:0]);
               emit_byte(b);
            end
            cv_pos++;
            cv_left--;
            if (cv_left == 0) cv_phase = PH_TAIL;
         end
         default: ;
      endcase
      if (fin) begin
         if (cv_seen < 6'd44) st = ST_SHORT;
         else if (cv_err != ST_OK) st = cv_err;
         else if (cv_phase == PH_DATA) st = ST_TRUNC;
         else if (cv_phase == PH_TAIL) st = ST_OK;
         else st = ST_FMT;
         r = '{kind: 1'b1, out_byte: 8'd0, status: st, run_end: 1'b0};
         step_out = {step_out, r};
         clear_parser();
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].run_end = 1'b1;
      expected_out = {expected_out, step_out};
   endtask

   // ---------------------------------------------------------------- files
   task automatic put_le(input logic [31:0] v, input int n);
      for (int i = 0; i < n; i++) file_buf = {file_buf, v[8*i +: 8]};
   endtask

   task automatic put_tag(input logic [31:0] t);
      for (int i = 3; i >= 0; i--) file_buf = {file_buf, t[8*i +: 8]};
   endtask

   task automatic put_noise(input int n);
      logic [7:0] nb;
      for (int i = 0; i < n; i++) begin
         nb = 8'($urandom);
         file_buf = {file_buf, nb};
      end
   endtask

   // one whole file; cut > 0 truncates it to that many bytes
   task automatic add_file(input flaw_type flaw, input int cut, input logic wide);
      int fl, dl, ul, at;
      logic [15:0] chans;
      req_type rq;
      file_buf.delete();
      put_tag(TAG_RIFF);
      put_noise(4);
      put_tag(TAG_WAVE);
      // corrupt one tag byte, never to the same value
      if (flaw == F_BAD_RIFF || flaw == F_BAD_WAVE) begin
         at = $urandom_range(0, 3) + (flaw == F_BAD_WAVE ? 8 : 0);
         file_buf[at] ^= 8'($urandom_range(1, 255));
      end
      // unknown chunk, odd sizes bring a pad byte
      if ($urandom_range(0, 1)) begin
         ul = $urandom_range(0, 3);
         put_tag(32'h4C495354);
         put_le(ul, 4);
         put_noise(ul + ul % 2);
      end
      if (flaw != F_NO_FMT && flaw != F_FMT_LATE) begin
         fl = (flaw == F_SMALL_FMT) ? 14 : ($urandom_range(0, 1) ? 16 : 18);
         chans = wide ? 16'hFFFF : 16'($urandom_range(1, 6));
         if (flaw == F_NO_CHAN) chans = 16'd0;
         put_tag(TAG_FMT);
         put_le(fl, 4);
         put_le(flaw == F_BAD_FMT ? 32'($urandom_range(2, 65535)) : 32'd1, 2);
         put_le({16'd0, chans}, 2);
         put_le(wide ? 32'hFFFF_FFFF : $urandom, 4);
         put_noise(6);
         if (fl >= 16) put_le(flaw == F_BAD_BITS ? 32'($urandom_range(0, 23)) : 32'd24, 2);
         put_noise(fl - 16 > 0 ? fl - 16 : 0);
      end
      if (flaw != F_NO_DATA) begin
         dl = 3 * $urandom_range(1, 4);
         if (flaw == F_BAD_SIZE) dl = dl + $urandom_range(1, 2);
         if (flaw == F_TINY_SIZE) dl = $urandom_range(0, 2);
         put_tag(TAG_DATA);
         put_le(dl, 4);
         put_noise(dl);
         if (flaw == F_FMT_LATE) begin
            put_tag(TAG_FMT);
            put_le(32'd16, 4);
            put_noise(16);
         end
         if ($urandom_range(0, 2) == 0) put_noise($urandom_range(1, 9));
      end
      if (cut > 0 && cut < file_buf.size()) file_buf = file_buf[0 : cut - 1];
      foreach (file_buf[i]) begin
         rq = '{in_byte: file_buf[i], is_final: (i == file_buf.size() - 1)};
         pending_bytes = {pending_bytes, rq};
      end
   endtask

   // --------------------------------------------------------------- driver
   int send_gap = 0;

   always @(posedge clock) begin
      logic go;
      go = 1'b0;
      if (!reset) begin
         if (req_push && !req_full) begin
            absorb_byte(req_item.in_byte, req_item.is_final);
            void'(pending_bytes.pop_front());
            bytes_sent++;
         end
         if (send_gap > 0) send_gap--;
         else if (pending_bytes.size() > 0) begin
            // one pause that lets the output side drain completely
            if (bytes_sent == drain_pause_at && expected_out.size() > 0) go = 1'b0;
            else if (!quiet && $urandom_range(0, 7) == 0)
               send_gap = $urandom_range(1, 12);
            else go = 1'b1;
         end
         if (total_bytes > 0 && bytes_sent >= (total_bytes * 3) / 4) quiet <= 1'b1;
      end
      req_push <= go;
      if (go) req_item <= pending_bytes[0];
   end

   // -------------------------------------------------------------- monitor
   int   pop_hold = 0;
   logic long_hold_done = 1'b0;

   always @(posedge clock) begin
      rsp_type want;
      logic pop;
      pop = 1'b0;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (expected_out.size() == 0) begin
               $error("result item with nothing expected: %p", rsp_item);
               fail_count++;
            end else begin
               want = expected_out.pop_front();
               if (rsp_item.kind !== want.kind) begin
                  $error("kind expected %0d actual %0d", want.kind, rsp_item.kind);
                  fail_count++;
               end
               if (rsp_item.out_byte !== want.out_byte) begin
                  $error("out_byte expected %0h actual %0h", want.out_byte,
                         rsp_item.out_byte);
                  fail_count++;
               end
               if (rsp_item.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_item.status);
                  fail_count++;
               end
               if (rsp_item.run_end !== want.run_end) begin
                  $error("run_end expected %0d actual %0d", want.run_end,
                         rsp_item.run_end);
                  fail_count++;
               end
            end
         end
         if (pop_hold > 0) pop_hold--;
         else if (!long_hold_done && results_seen >= 30) begin
            // long back-pressure so the command queue fills and req_full rises
            pop_hold = 300;
            long_hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0)
            pop_hold = $urandom_range(1, 12);
         else pop = 1'b1;
      end
      rsp_pop <= pop;
   end

   // ------------------------------------------------------------- stimulus
   initial begin
      flaw_type f;
      int room;
      clear_parser();
      // directed: short file with a broken tag, file cut after a broken wave
      // tag, then an extreme good file
      add_file(F_BAD_RIFF, 6, 1'b0);
      add_file(F_BAD_WAVE, 16, 1'b0);
      add_file(F_GOOD, 0, 1'b1);
      // random files, the last one cut to keep the run near 100 bytes
      while (pending_bytes.size() < 100) begin
         room = 100 - pending_bytes.size();
         f = ($urandom_range(0, 1)) ? F_GOOD : flaw_type'($urandom_range(0, 11));
         add_file(f, room, $urandom_range(0, 7) == 0);
      end
      total_bytes = pending_bytes.size();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (pending_bytes.size() > 0 || expected_out.size() > 0) @(posedge clock);
      // header burst latency plus queue depth
      repeat (60) @(posedge clock);
      if (fail_count == 0 && expected_out.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule

@@ sim.f @@
src/wavcv_pkg.sv
src/wavcv_parser.sv
src/wavcv_queue.sv
src/wavcv_emitter.sv
src/wavcv_outbuf.sv
src/wav_pcm24_to_pcm16_converter_unit.sv
tb/wav_pcm24_to_pcm16_converter_unit_tb.sv
